// File: rtl/yuy2_to_rgb_converter_top_assert.svh
// Assertion macros shared by the YUY2 to RGB converter RTL.
`ifndef YUY2_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define YUY2_TO_RGB_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define YRC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("yrc assertion failed");
// Next-cycle implication, disabled during reset.
`define YRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("yrc assertion failed");
`else
`define YRC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define YRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/yrc_pkg.sv
// Package: widths, register map, coefficient tables and clip function.
`timescale 1ns / 1ps
`default_nettype none

package yrc_pkg;

  localparam int TERM_W = 26;  // one fixed-point term, 16 fraction bits
  localparam int SUM_W  = 28;  // sum of up to three terms

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_COEF_SET = 2'd0;

  localparam logic MODE_STUDIO = 1'b0;
  localparam logic MODE_FULL   = 1'b1;

  localparam longint StudioDen = 1000;
  localparam longint FullDen   = 100000;

  typedef logic signed [TERM_W-1:0] term_tab_t [256];

  typedef struct packed {
    logic adv_sum;  // load the sum stage
    logic adv_out;  // load the clip/output stage
  } yrc_ctl_t;

  // trunc(num * (i - 128) * 2^16 / 1000)
  function automatic term_tab_t build_studio_tab(input longint num);
    term_tab_t tab;
    longint    v;
    for (int i = 0; i < 256; i++) begin
      v = (num * (i - 128) * 65536) / StudioDen;
      tab[i] = v[TERM_W-1:0];
    end
    return tab;
  endfunction

  // trunc(num * (i - 128) * 2^16 / 100000)
  function automatic term_tab_t build_full_tab(input longint num);
    term_tab_t tab;
    longint    v;
    for (int i = 0; i < 256; i++) begin
      v = (num * (i - 128) * 65536) / FullDen;
      tab[i] = v[TERM_W-1:0];
    end
    return tab;
  endfunction

  // trunc(1.164 * (y - 16)) * 2^16
  function automatic term_tab_t build_luma_tab();
    term_tab_t tab;
    longint    v;
    for (int i = 0; i < 256; i++) begin
      v = ((1164 * (i - 16)) / StudioDen) * 65536;
      tab[i] = v[TERM_W-1:0];
    end
    return tab;
  endfunction

  localparam term_tab_t TAB_LUMA_STUDIO = build_luma_tab();
  localparam term_tab_t TAB_VR_STUDIO   = build_studio_tab(1596);
  localparam term_tab_t TAB_UG_STUDIO   = build_studio_tab(-392);
  localparam term_tab_t TAB_VG_STUDIO   = build_studio_tab(-813);
  localparam term_tab_t TAB_UB_STUDIO   = build_studio_tab(2017);
  localparam term_tab_t TAB_VR_FULL     = build_full_tab(140200);
  localparam term_tab_t TAB_UG_FULL     = build_full_tab(-34414);
  localparam term_tab_t TAB_VG_FULL     = build_full_tab(-71414);
  localparam term_tab_t TAB_UB_FULL     = build_full_tab(177200);

  // Arithmetic shift by 16 (floor), then clip to 0..255.
  function automatic logic [7:0] clip_shift(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-17:0] q;
    logic [7:0] res;
    q = s[SUM_W-1:16];
    if (q < 0) begin
      res = 8'd0;
    end else if (q > 255) begin
      res = 8'd255;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/yrc_pixel.sv
// One pixel's channel sums and clip stages.
`timescale 1ns / 1ps
`default_nettype none

module yrc_pixel (
  input  wire logic                                 clk,
  input  wire yrc_pkg::yrc_ctl_t                    ctl,
  input  wire logic signed [yrc_pkg::TERM_W-1:0]    luma_term,
  input  wire logic signed [yrc_pkg::TERM_W-1:0]    term_vr,
  input  wire logic signed [yrc_pkg::TERM_W-1:0]    term_ug,
  input  wire logic signed [yrc_pkg::TERM_W-1:0]    term_vg,
  input  wire logic signed [yrc_pkg::TERM_W-1:0]    term_ub,
  output logic [7:0]                                red,
  output logic [7:0]                                green,
  output logic [7:0]                                blue
);

  logic signed [yrc_pkg::SUM_W-1:0] sum_r;
  logic signed [yrc_pkg::SUM_W-1:0] sum_g;
  logic signed [yrc_pkg::SUM_W-1:0] sum_b;
  logic signed [yrc_pkg::SUM_W-1:0] ly;

  assign ly = yrc_pkg::SUM_W'(luma_term);

  always_ff @(posedge clk) begin
    if (ctl.adv_sum) begin
      sum_r <= ly + yrc_pkg::SUM_W'(term_vr);
      sum_g <= ly + yrc_pkg::SUM_W'(term_ug) + yrc_pkg::SUM_W'(term_vg);
      sum_b <= ly + yrc_pkg::SUM_W'(term_ub);
    end
    if (ctl.adv_out) begin
      red   <= yrc_pkg::clip_shift(sum_r);
      green <= yrc_pkg::clip_shift(sum_g);
      blue  <= yrc_pkg::clip_shift(sum_b);
    end
  end

endmodule

`default_nettype wire

// File: rtl/yuy2_to_rgb_converter_top.sv
// Top level: YUY2 macropixel to two RGB pixels, BT.601 studio or full range.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   luma_first chroma_v luma_second chroma_u frame_end_in
//  out      output     out_valid / out_stall red/green/blue_first, red/green/blue_second,
//                                            frame_end_out
//  cfg      APB slave  psel penable pready   coefficient_set at byte address 0
//
// One item per clock sustained while out_stall is low; stages are capture, table lookup,
// channel add and clip. Table reads sit in the lookup stage, term adds in the add stage.
// Synchronous active-high reset clears the valid bits and coefficient_set (studio range).
// A stage loads when it is empty or the one after it moves, so out_stall backs up only
// as far as there are full stages; bubbles are squeezed out and nothing repeats.
`timescale 1ns / 1ps
`default_nettype none

module yuy2_to_rgb_converter_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  luma_first,
  input  wire logic [7:0]                  chroma_v,
  input  wire logic [7:0]                  luma_second,
  input  wire logic [7:0]                  chroma_u,
  input  wire logic                        frame_end_in,
  // output channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       red_first,
  output logic [7:0]                       green_first,
  output logic [7:0]                       blue_first,
  output logic [7:0]                       red_second,
  output logic [7:0]                       green_second,
  output logic [7:0]                       blue_second,
  output logic                             frame_end_out,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [yrc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // ---------------- configuration register ----------------
  logic coef_set;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == yrc_pkg::REG_COEF_SET);
  assign prdata = (paddr == yrc_pkg::REG_COEF_SET) ? {31'd0, coef_set} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_set <= yrc_pkg::MODE_STUDIO;
    end else if (cfg_wr) begin
      coef_set <= pwdata[0];
    end
  end

  // ---------------- stage control ----------------
  // a: captured input, b: looked-up terms, c: sums, d: clipped output
  logic valid_a, valid_b, valid_c;
  logic ready_a, ready_b, ready_c, ready_d;
  yrc_pkg::yrc_ctl_t pix_ctl;

  assign ready_d = !out_valid || !out_stall;
  assign ready_c = !valid_c || ready_d;
  assign ready_b = !valid_b || ready_c;
  assign ready_a = !valid_a || ready_b;
  assign in_stall = !ready_a;

  assign pix_ctl.adv_sum = ready_c;
  assign pix_ctl.adv_out = ready_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      valid_c   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_a) valid_a   <= in_valid;
      if (ready_b) valid_b   <= valid_a;
      if (ready_c) valid_c   <= valid_b;
      if (ready_d) out_valid <= valid_c;
    end
  end

  // ---------------- stage a: capture ----------------
  logic [7:0] y0_a, v_a, y1_a, u_a;
  logic       fe_a, mode_a;

  always_ff @(posedge clk) begin
    if (ready_a) begin
      y0_a   <= luma_first;
      v_a    <= chroma_v;
      y1_a   <= luma_second;
      u_a    <= chroma_u;
      fe_a   <= frame_end_in;
      mode_a <= coef_set;
    end
  end

  // ---------------- stage b: table lookup ----------------
  logic signed [yrc_pkg::TERM_W-1:0] ty0_b, ty1_b, tvr_b, tug_b, tvg_b, tub_b;
  logic                              fe_b, fe_c;
  logic signed [yrc_pkg::TERM_W-1:0] ty0_next, ty1_next;

  // full range: Y * 2^16 exactly; studio: truncated 1.164*(Y-16), then scaled
  always_comb begin
    if (mode_a == yrc_pkg::MODE_FULL) begin
      ty0_next = {2'b00, y0_a, 16'd0};
      ty1_next = {2'b00, y1_a, 16'd0};
    end else begin
      ty0_next = yrc_pkg::TAB_LUMA_STUDIO[y0_a];
      ty1_next = yrc_pkg::TAB_LUMA_STUDIO[y1_a];
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b) begin
      ty0_b <= ty0_next;
      ty1_b <= ty1_next;
      if (mode_a == yrc_pkg::MODE_FULL) begin
        tvr_b <= yrc_pkg::TAB_VR_FULL[v_a];
        tug_b <= yrc_pkg::TAB_UG_FULL[u_a];
        tvg_b <= yrc_pkg::TAB_VG_FULL[v_a];
        tub_b <= yrc_pkg::TAB_UB_FULL[u_a];
      end else begin
        tvr_b <= yrc_pkg::TAB_VR_STUDIO[v_a];
        tug_b <= yrc_pkg::TAB_UG_STUDIO[u_a];
        tvg_b <= yrc_pkg::TAB_VG_STUDIO[v_a];
        tub_b <= yrc_pkg::TAB_UB_STUDIO[u_a];
      end
      fe_b <= fe_a;
    end
    if (ready_c) fe_c <= fe_b;
    if (ready_d) frame_end_out <= fe_c;
  end

  // ---------------- stages c and d: sums and clip, per pixel ----------------
  yrc_pixel u_pix_first (
    .clk       (clk),
    .ctl       (pix_ctl),
    .luma_term (ty0_b),
    .term_vr   (tvr_b),
    .term_ug   (tug_b),
    .term_vg   (tvg_b),
    .term_ub   (tub_b),
    .red       (red_first),
    .green     (green_first),
    .blue      (blue_first)
  );

  yrc_pixel u_pix_second (
    .clk       (clk),
    .ctl       (pix_ctl),
    .luma_term (ty1_b),
    .term_vr   (tvr_b),
    .term_ug   (tug_b),
    .term_vg   (tvg_b),
    .term_ub   (tub_b),
    .red       (red_second),
    .green     (green_second),
    .blue      (blue_second)
  );

  // ---------------- assertions ----------------
`include "yuy2_to_rgb_converter_top_assert.svh"

  // input is held off only when every stage is full and the output is blocked
  `YRC_ASSERT_IMPLIES(a_stall_full, clk, rst, in_stall, valid_a && valid_b && valid_c && out_valid && out_stall)
  // a full sum stage behind a blocked output keeps its item
  `YRC_ASSERT_NEXT(a_sum_hold, clk, rst, valid_c && out_valid && out_stall, valid_c)
  // frame marker moves into the output stage with its item
  `YRC_ASSERT_NEXT(a_fe_move, clk, rst, valid_c && ready_d, out_valid && (frame_end_out == $past(fe_c)))
  // a register write lands on the next edge
  `YRC_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_wr, coef_set == $past(pwdata[0]))

endmodule

`default_nettype wire
